[hw/rtl/lbp3_pkg.sv]
// ============================================================================
// lbp3_pkg
// Shared constants, register codes and types of the 3x3 LBP code block.
// ============================================================================
package lbp3_pkg;

    // line buffer size and derived widths
    localparam int MAX_WIDTH = 1024;
    localparam int W_COL     = $clog2(MAX_WIDTH);     // column index
    localparam int W_WID     = W_COL + 1;             // width value, holds MAX_WIDTH
    localparam int W_ROW     = 12;                    // row index and height
    localparam int W_RNX     = W_ROW + 1;             // row plus one, no overflow
    localparam int W_PIX     = 8;

    // configuration port
    localparam int W_CFG     = 12;
    localparam int W_CFG_IDX = 1;
    localparam logic [W_CFG_IDX-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [W_CFG_IDX-1:0] CFG_IMAGE_HEIGHT = 1'b1;
    localparam logic [W_WID-1:0]     RST_WIDTH        = W_WID'(100);
    localparam logic [W_ROW-1:0]     RST_HEIGHT       = W_ROW'(100);
    localparam int                   MIN_SIZE         = 3;

    // output queue, depth a power of two
    localparam int OUT_DEPTH = 4;
    localparam int W_OPTR    = $clog2(OUT_DEPTH);
    localparam int W_OCNT    = $clog2(OUT_DEPTH + 1);

    // code bit positions, clockwise from top-left
    localparam int BIT_TL = 7;
    localparam int BIT_T  = 6;
    localparam int BIT_TR = 5;
    localparam int BIT_R  = 4;
    localparam int BIT_BR = 3;
    localparam int BIT_B  = 2;
    localparam int BIT_BL = 1;
    localparam int BIT_L  = 0;

    typedef struct packed {
        logic [W_COL-1:0] x;
        logic             emit;   // centre is interior
        logic             last;   // last interior pixel of the frame
    } t_pos_info;

    typedef struct packed {
        logic [W_PIX-1:0] code;
        logic             last;
    } t_result;

endpackage

[hw/rtl/lbp3_ram.sv]
// ============================================================================
// lbp3_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module lbp3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/lbp3_pos.sv]
// ============================================================================
// lbp3_pos
// Frame size registers and raster position counters for incoming pixels.
// ============================================================================
module lbp3_pos (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lbp3_pkg::W_CFG_IDX-1:0]   i_cfg_index,
    input  logic [lbp3_pkg::W_CFG-1:0]       i_cfg_data,
    input  logic                             i_accept,
    input  logic                             i_frame_start,
    output lbp3_pkg::t_pos_info              o_pos
);
    import lbp3_pkg::*;

    logic [W_WID-1:0] r_width,  n_width;   // already clamped to 3..MAX_WIDTH
    logic [W_ROW-1:0] r_height, n_height;  // already raised to at least 3
    logic [W_COL-1:0] r_col,    n_col;
    logic [W_ROW-1:0] r_row,    n_row;

    logic [W_WID-1:0] s_cfg_w;
    logic [W_ROW-1:0] s_cfg_h;
    logic [W_WID-1:0] s_col_in, s_x, s_x_inc;
    logic [W_RNX-1:0] s_row_in, s_y0, s_y, s_y_inc;

    // size registers
    always_comb begin
        s_cfg_w  = i_cfg_data[W_WID-1:0];
        s_cfg_h  = i_cfg_data[W_ROW-1:0];
        n_width  = r_width;
        n_height = r_height;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH: begin
                    if (s_cfg_w < W_WID'(MIN_SIZE)) begin
                        n_width = W_WID'(MIN_SIZE);
                    end else if (s_cfg_w > W_WID'(MAX_WIDTH)) begin
                        n_width = W_WID'(MAX_WIDTH);
                    end else begin
                        n_width = s_cfg_w;
                    end
                end
                CFG_IMAGE_HEIGHT: begin
                    n_height = (s_cfg_h < W_ROW'(MIN_SIZE)) ? W_ROW'(MIN_SIZE) : s_cfg_h;
                end
                default: begin
                    n_width  = r_width;
                    n_height = r_height;
                end
            endcase
        end
    end

    // position of the pixel on the input now, and where the next one lands
    always_comb begin
        s_col_in = i_frame_start ? '0 : {1'b0, r_col};
        s_row_in = i_frame_start ? '0 : {1'b0, r_row};
        // a column past a shrunk width starts a new row first
        if (s_col_in >= r_width) begin
            s_x  = '0;
            s_y0 = s_row_in + W_RNX'(1);
        end else begin
            s_x  = s_col_in;
            s_y0 = s_row_in;
        end
        s_y = (s_y0 >= {1'b0, r_height}) ? '0 : s_y0;

        o_pos.x    = s_x[W_COL-1:0];
        o_pos.emit = (s_x >= W_WID'(2)) && (s_y >= W_RNX'(2));
        o_pos.last = (s_x == r_width - W_WID'(1)) && (s_y == {1'b0, r_height} - W_RNX'(1));

        s_x_inc = s_x + W_WID'(1);
        s_y_inc = s_y + W_RNX'(1);
        n_col   = r_col;
        n_row   = r_row;
        if (i_accept) begin
            if (s_x_inc >= r_width) begin
                n_col = '0;
                n_row = (s_y_inc >= {1'b0, r_height}) ? '0 : s_y_inc[W_ROW-1:0];
            end else begin
                n_col = s_x_inc[W_COL-1:0];
                n_row = s_y[W_ROW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
            r_col    <= n_col;
            r_row    <= n_row;
        end
    end

endmodule

[hw/rtl/lbp3_window.sv]
// ============================================================================
// lbp3_window
// Six-register 3x3 window and the eight neighbour compares of the centre.
// ============================================================================
module lbp3_window (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  lbp3_pkg::t_pos_info          i_pos,
    input  logic [lbp3_pkg::W_PIX-1:0]   i_top,
    input  logic [lbp3_pkg::W_PIX-1:0]   i_mid,
    input  logic [lbp3_pkg::W_PIX-1:0]   i_bot,
    output logic                         o_res_valid,
    output lbp3_pkg::t_result            o_res
);
    import lbp3_pkg::*;

    // per row: [0]/[1] top, [2]/[3] middle, [4]/[5] bottom; even = two columns back
    logic [W_PIX-1:0] r_win [6];
    logic [W_PIX-1:0] s_c;

    always_comb begin
        s_c                = r_win[3];
        o_res.code         = '0;
        o_res.code[BIT_TL] = r_win[0] > s_c;
        o_res.code[BIT_T]  = r_win[1] > s_c;
        o_res.code[BIT_TR] = i_top    > s_c;
        o_res.code[BIT_R]  = i_mid    > s_c;
        o_res.code[BIT_BR] = i_bot    > s_c;
        o_res.code[BIT_B]  = r_win[5] > s_c;
        o_res.code[BIT_BL] = r_win[4] > s_c;
        o_res.code[BIT_L]  = r_win[2] > s_c;
        o_res.last         = i_pos.last;
        o_res_valid        = i_valid && i_pos.emit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_valid) begin
            r_win[0] <= r_win[1];
            r_win[1] <= i_top;
            r_win[2] <= r_win[3];
            r_win[3] <= i_mid;
            r_win[4] <= r_win[5];
            r_win[5] <= i_bot;
        end
    end

endmodule

[hw/rtl/lbp3_out_fifo.sv]
// ============================================================================
// lbp3_out_fifo
// Small result queue that decouples the pipeline from the output stall.
// ============================================================================
module lbp3_out_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  lbp3_pkg::t_result             i_data,
    output logic [lbp3_pkg::W_OCNT-1:0]   o_count,
    output logic                          o_valid,
    input  logic                          i_ready,
    output lbp3_pkg::t_result             o_data
);
    import lbp3_pkg::*;

    t_result           r_mem [OUT_DEPTH];
    logic [W_OPTR-1:0] r_wr_ptr, n_wr_ptr;
    logic [W_OPTR-1:0] r_rd_ptr, n_rd_ptr;
    logic [W_OCNT-1:0] r_count,  n_count;
    logic              s_pop;

    always_comb begin
        s_pop    = o_valid && i_ready;
        n_wr_ptr = i_push ? r_wr_ptr + W_OPTR'(1) : r_wr_ptr;
        n_rd_ptr = s_pop  ? r_rd_ptr + W_OPTR'(1) : r_rd_ptr;
        n_count  = r_count + W_OCNT'(i_push) - W_OCNT'(s_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_count = r_count;
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

[hw/rtl/lbp_3x3_code_top.sv]
// ============================================================================
// lbp_3x3_code_top
// Streaming 3x3 local binary pattern coder over a raster pixel stream.
// ============================================================================
// Input channel (i_valid/o_ready) takes one grey pixel per item in raster
// order; i_frame_start on an item puts it at column 0, row 0. The frame size
// comes from the write port (index 0 width, index 1 height); the user must
// write it only while no item is in flight; the block does not enforce this.
// Reset sets the size to 100 x 100 and the position to the frame origin; line
// buffers are not cleared, and rows are always written before they are read.
// Each pixel that completes a window around an interior centre gives one
// item on the output channel (o_valid/i_ready): the 8-bit code, bit 7 the
// top-left neighbour and clockwise to bit 0 left, plus o_frame_last on the
// last interior pixel. Pixels in the first two columns or rows give no item.
// One pixel per clock sustained while o_ready is high; each code passes the
// compare stage and the output queue. Each pixel makes one read and one write
// to both line buffer RAMs; a same-column access in consecutive items is
// forwarded. When the receiver stalls, up to four codes queue; o_ready drops
// when the queue plus the item in the compare stage could fill it.
// ============================================================================
module lbp_3x3_code_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [7:0]                       i_pixel,
    input  logic                             i_frame_start,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [7:0]                       o_lbp_code,
    output logic                             o_frame_last,
    input  logic                             i_cfg_we,
    input  logic [lbp3_pkg::W_CFG_IDX-1:0]   i_cfg_index,
    input  logic [lbp3_pkg::W_CFG-1:0]       i_cfg_data
);
    import lbp3_pkg::*;

    logic              s_accept;
    t_pos_info         s_pos;
    logic [W_OCNT-1:0] s_fifo_count;
    logic [W_PIX-1:0]  s_rd_a, s_rd_b, s_top, s_mid;
    logic              s_res_valid;
    t_result           s_res, s_out;

    // compare stage
    logic              r_s1_valid;
    t_pos_info         r_s1_pos;
    logic [W_PIX-1:0]  r_s1_bot;
    logic              r_s1_fwd;
    logic [W_PIX-1:0]  r_fwd_top, r_fwd_mid;

    assign o_ready  = ({1'b0, s_fifo_count} + (W_OCNT+1)'(r_s1_valid)) < (W_OCNT+1)'(OUT_DEPTH);
    assign s_accept = i_valid && o_ready;

    lbp3_pos u_pos (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (s_accept),
        .i_frame_start (i_frame_start),
        .o_pos         (s_pos)
    );

    // line_a: row above, line_b: row two above
    lbp3_ram #(.WIDTH(W_PIX), .DEPTH(MAX_WIDTH)) u_line_a (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_pos.x),
        .i_wdata (r_s1_bot),
        .i_raddr (s_pos.x),
        .o_rdata (s_rd_a)
    );

    lbp3_ram #(.WIDTH(W_PIX), .DEPTH(MAX_WIDTH)) u_line_b (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_pos.x),
        .i_wdata (s_mid),
        .i_raddr (s_pos.x),
        .o_rdata (s_rd_b)
    );

    // a read that collides with the write of the previous item takes its data
    assign s_top = r_s1_fwd ? r_fwd_top : s_rd_b;
    assign s_mid = r_s1_fwd ? r_fwd_mid : s_rd_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_fwd   <= 1'b0;
        end else begin
            r_s1_valid <= s_accept;
            r_s1_fwd   <= s_accept && r_s1_valid && (s_pos.x == r_s1_pos.x);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_pos <= s_pos;
            r_s1_bot <= i_pixel;
        end
        if (r_s1_valid) begin
            r_fwd_top <= s_mid;
            r_fwd_mid <= r_s1_bot;
        end
    end

    lbp3_window u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_s1_valid),
        .i_pos       (r_s1_pos),
        .i_top       (s_top),
        .i_mid       (s_mid),
        .i_bot       (r_s1_bot),
        .o_res_valid (s_res_valid),
        .o_res       (s_res)
    );

    lbp3_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_res_valid),
        .i_data  (s_res),
        .o_count (s_fifo_count),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (s_out)
    );

    assign o_lbp_code   = s_out.code;
    assign o_frame_last = s_out.last;

    a_accept_to_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> r_s1_valid)
        else $error("accepted item did not reach the compare stage");

    a_fwd_same_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_fwd |-> (r_s1_valid && $past(r_s1_valid) && r_s1_pos.x == $past(r_s1_pos.x)))
        else $error("forwarding without a same-column write");

    a_last_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_pos.last) |-> s_res_valid)
        else $error("frame end flagged on a border pixel");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_res_valid && s_fifo_count == W_OCNT'(OUT_DEPTH) && !(o_valid && i_ready)))
        else $error("result queue overflow");

endmodule
